// ----- hdl/stbs_pkg.sv -----
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared constants for the sorted table binary search block: operation codes,
// item field widths and default sizes.
// ----------------------------------------------------------------------------
package stbs_pkg;

   // item field widths
   localparam int OP_W    = 2;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 10;

   // default table geometry
   localparam int DEFAULT_DEPTH       = 1024;
   localparam int DEFAULT_VALUE_WIDTH = 32;

   // operation codes
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

endpackage

// ----- hdl/stbs_if.sv -----
// ----------------------------------------------------------------------------
// stbs_if
// Valid/ready channels of the sorted table binary search block: the request
// channel (operation and value) and the response channel (found, position).
// ----------------------------------------------------------------------------
interface stbs_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [stbs_pkg::OP_W-1:0]            operation;
   logic signed [stbs_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output operation, output value, input ready);
   modport sink   (input valid, input operation, input value, output ready);
endinterface

interface stbs_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        found;
   logic [stbs_pkg::POS_W-1:0]  position;

   modport source (output valid, output found, output position, input ready);
   modport sink   (input valid, input found, input position, output ready);
endinterface

// ----- hdl/sorted_table_binary_search_top.sv -----
// ----------------------------------------------------------------------------
// sorted_table_binary_search_top
// Table of signed values loaded in ascending order, searched by binary search.
// ----------------------------------------------------------------------------
// Clear and append items are taken only while idle and never produce a
// response. A search item is accepted and then probes the table, one probe
// at a time: the probe loop is a single-port synchronous table read with a
// registered output, and the compare result of one probe picks the next read
// address in the same cycle. A search over n entries makes at most
// floor(log2(n))+1 probes, and an empty table answers without a probe. The
// response sits in an output register, and while it waits clear and append
// items are still taken; a finished search that finds that register occupied
// waits in a hold state. The table has no reset of its own, only the entry
// count is cleared.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_top #(
   parameter int DEPTH       = stbs_pkg::DEFAULT_DEPTH,
   parameter int VALUE_WIDTH = stbs_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   stbs_req_if.sink   req,
   stbs_rsp_if.source rsp
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // sequencer state codes
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PROBE = 2'd1;
   localparam logic [1:0] ST_HOLD  = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [CNT_W-1:0]              lo_ff, lo_in;
   logic [CNT_W-1:0]              end_ff, end_in;
   logic [IDX_W-1:0]              mid_ff, mid_in;
   logic signed [VALUE_WIDTH-1:0] key_ff, key_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic [stbs_pkg::POS_W-1:0]    rsp_pos_ff, rsp_pos_in;
   logic                          res_found_ff, res_found_in;
   logic [stbs_pkg::POS_W-1:0]    res_pos_ff, res_pos_in;

   logic signed [VALUE_WIDTH-1:0] mem [DEPTH];
   logic signed [VALUE_WIDTH-1:0] rd_data_ff;
   logic                          rd_en;
   logic                          wr_en;

   logic                          req_take;
   logic signed [VALUE_WIDTH-1:0] req_key;
   logic                          out_free;
   logic                          hit;
   logic                          key_gt;
   logic [CNT_W-1:0]              mid_ext;
   logic [CNT_W-1:0]              lo_nx;
   logic [CNT_W-1:0]              end_nx;
   logic [CNT_W:0]                mid_sum;
   logic [CNT_W-1:0]              first_mid;

   assign req.ready    = (state_ff == ST_IDLE);
   assign req_take     = req.valid && req.ready;
   assign req_key      = VALUE_WIDTH'(req.value);
   assign out_free     = !rsp_valid_ff || rsp.ready;

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.found    = rsp_found_ff;
   assign rsp.position = rsp_pos_ff;

   // probe compare and narrowed bounds
   assign hit     = (key_ff == rd_data_ff);
   assign key_gt  = (key_ff > rd_data_ff);
   assign mid_ext = CNT_W'(mid_ff);
   assign lo_nx   = key_gt ? CNT_W'(mid_ext + 1'b1) : lo_ff;
   assign end_nx  = key_gt ? end_ff : mid_ext;
   assign mid_sum = {1'b0, lo_nx} + {1'b0, end_nx} - 1'b1;

   // midpoint of the full table for the first probe
   assign first_mid = CNT_W'((cnt_ff - 1'b1) >> 1);

   // sequencer and output register
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      lo_in        = lo_ff;
      end_in       = end_ff;
      mid_in       = mid_ff;
      key_in       = key_ff;
      res_found_in = res_found_ff;
      res_pos_in   = res_pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req.operation)
                  stbs_pkg::OP_CLEAR: begin
                     cnt_in = '0;
                  end
                  stbs_pkg::OP_APPEND: begin
                     if (cnt_ff < CNT_W'(DEPTH)) begin
                        wr_en  = 1'b1;
                        cnt_in = cnt_ff + 1'b1;
                     end
                  end
                  stbs_pkg::OP_SEARCH: begin
                     key_in = req_key;
                     lo_in  = '0;
                     end_in = cnt_ff;
                     if (cnt_ff == '0) begin
                        // empty table answers at once
                        res_found_in = 1'b0;
                        res_pos_in   = '0;
                        if (out_free) begin
                           rsp_valid_in = 1'b1;
                           rsp_found_in = 1'b0;
                           rsp_pos_in   = '0;
                        end else begin
                           state_in = ST_HOLD;
                        end
                     end else begin
                        mid_in   = first_mid[IDX_W-1:0];
                        rd_en    = 1'b1;
                        state_in = ST_PROBE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PROBE: begin
            if (hit || !(lo_nx < end_nx)) begin
               res_found_in = hit;
               res_pos_in   = hit ? stbs_pkg::POS_W'(mid_ff) : '0;
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_found_in = hit;
                  rsp_pos_in   = hit ? stbs_pkg::POS_W'(mid_ff) : '0;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end else begin
               lo_in  = lo_nx;
               end_in = end_nx;
               mid_in = mid_sum[IDX_W:1];
               rd_en  = 1'b1;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_pos_in   = res_pos_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      end_ff       <= end_in;
      mid_ff       <= mid_in;
      key_ff       <= key_in;
      res_found_ff <= res_found_in;
      res_pos_ff   <= res_pos_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   // table memory, one write or one read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cnt_ff[IDX_W-1:0]] <= req_key;
      end
      if (rd_en) begin
         rd_data_ff <= mem[mid_in];
      end
   end

   // entry count never runs past the table
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond table depth");

   // search bounds stay ordered and inside the loaded entries
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> (lo_ff < end_ff) && (end_ff <= cnt_ff))
      else $error("search bounds out of order");

   // probe address lies inside the current bounds
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> (mid_ext >= lo_ff) && (mid_ext < end_ff))
      else $error("probe outside search bounds");

   // a search of an empty table with a free output answers next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_take && (req.operation == stbs_pkg::OP_SEARCH) && (cnt_ff == '0) && out_free
      |=> rsp_valid_ff && !rsp_found_ff && (rsp_pos_ff == '0))
      else $error("empty table search missed its response");

endmodule
